// ----- rtl/rtlpm_pkg.sv -----
`default_nettype none
package rtlpm_pkg;

  typedef enum logic [1:0] {
    OP_WR_IFACE  = 2'd0,
    OP_WR_STATIC = 2'd1,
    OP_SET_OPER  = 2'd2,
    OP_LOOKUP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_IFACE  = 2'd1,
    ST_STATIC = 2'd2,
    ST_DONE   = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  slot;
    logic [31:0] address;
    logic [5:0]  pfx_len;
    logic [7:0]  preference;
    logic        admin_up;
    logic        oper_up;
    logic        egress_valid;
    logic [3:0]  egress_index;
    logic [31:0] hop_addr;
    logic        hop_valid;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  out_interface;
    logic        is_direct;
    logic [31:0] out_hop;
    logic [31:0] route_prefix;
    logic [5:0]  route_len;
    logic        from_static;
    logic [7:0]  route_preference;
  } out_item_t;

  function automatic logic [5:0] clamp_len(input logic [5:0] len);
    return (len > 6'd32) ? 6'd32 : len;
  endfunction

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [5:0] l;
    l = clamp_len(len);
    if (l == 6'd0) return 32'd0;
    return 32'hFFFF_FFFF << (6'd32 - l);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rtlpm_if.sv -----
`default_nettype none
interface rtlpm_in_if;
  logic                 valid;
  logic                 ready;
  rtlpm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rtlpm_out_if;
  logic                 valid;
  logic                 ready;
  rtlpm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/route_table_lpm_lookup_top.sv -----
`default_nettype none
// Route table with longest-prefix-match lookup. Every item gives exactly one result.
// A write or oper-state change is applied when the item is accepted; the FSM then goes
// to DONE, which registers the result once the output register is free, and back to
// IDLE, where the next item can be taken. A lookup walks the interface table, one entry
// per cycle, then the static table, one entry per cycle, through one shared
// mask/compare/select unit; a static entry's next hop is checked against all interfaces
// at once. After the last static entry, DONE registers the lookup result once the output
// register is free and the FSM returns to IDLE for the next item. A new item
// may be taken while the previous result still waits in the output register; its own
// result is then held back until that register is free. At reset all interfaces are
// down and all routes invalid; the other table fields are not cleared.
module route_table_lpm_lookup_top #(
  parameter int NUM_IFACES = 16,
  parameter int NUM_STATIC = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rtlpm_in_if.sink        in_ch,
  rtlpm_out_if.source     out_ch
);

  localparam int IW = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int SW = (NUM_STATIC > 1) ? $clog2(NUM_STATIC) : 1;

  logic [31:0] if_addr_r  [NUM_IFACES];
  logic [5:0]  if_len_r   [NUM_IFACES];
  logic [NUM_IFACES-1:0] if_admin_r, if_oper_r;

  logic [31:0] st_pfx_r [NUM_STATIC];
  logic [5:0]  st_len_r [NUM_STATIC];
  logic [7:0]  st_pref_r [NUM_STATIC];
  logic [3:0]  st_eg_r [NUM_STATIC];
  logic [31:0] st_hop_r [NUM_STATIC];
  logic [NUM_STATIC-1:0] st_valid_r, st_haseg_r, st_hashop_r;

  rtlpm_pkg::state_t state_r, state_nxt;
  rtlpm_pkg::in_item_t item_r;
  logic [IW-1:0] iidx_r;
  logic [SW-1:0] sidx_r;

  logic        have_r;
  logic [5:0]  b_len_r;
  logic [7:0]  b_pref_r;
  logic [3:0]  b_if_r;
  logic [31:0] b_hop_r, b_net_r;
  logic        b_direct_r, b_static_r;

  logic                 out_valid_r;
  rtlpm_pkg::out_item_t out_data_r;

  logic in_fire, last_if, last_st;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign last_if = (int'(iidx_r) == NUM_IFACES - 1);
  assign last_st = (int'(sidx_r) == NUM_STATIC - 1);

  logic [NUM_IFACES-1:0] up;
  assign up = if_admin_r & if_oper_r;

  // shared candidate unit
  logic        c_ok;
  logic [5:0]  c_len;
  logic [7:0]  c_pref;
  logic [3:0]  c_if;
  logic [31:0] c_hop, c_net, c_base;
  logic        c_direct, c_static;
  logic        hop_hit;
  logic [3:0]  hop_if;
  logic [31:0] c_mask;

  always_comb begin
    hop_hit = 1'b0;
    hop_if  = '0;
    for (int i = NUM_IFACES - 1; i >= 0; i--) begin
      if (up[i] && ((st_hop_r[sidx_r] & rtlpm_pkg::len_mask(if_len_r[i])) ==
                    (if_addr_r[i] & rtlpm_pkg::len_mask(if_len_r[i])))) begin
        hop_hit = 1'b1;
        hop_if  = 4'(i);
      end
    end
  end

  always_comb begin
    c_ok = 1'b0; c_len = '0; c_pref = '0; c_if = '0; c_hop = '0; c_base = '0;
    c_direct = 1'b0; c_static = 1'b0;
    if (state_r == rtlpm_pkg::ST_IFACE) begin
      c_ok   = up[iidx_r];
      c_len  = rtlpm_pkg::clamp_len(if_len_r[iidx_r]);
      c_if   = 4'(iidx_r);
      c_base = if_addr_r[iidx_r];
      c_direct = 1'b1;
    end else begin
      c_len  = rtlpm_pkg::clamp_len(st_len_r[sidx_r]);
      c_pref = st_pref_r[sidx_r];
      c_base = st_pfx_r[sidx_r];
      c_static = 1'b1;
      if (st_haseg_r[sidx_r]) begin
        c_ok = st_valid_r[sidx_r] && (32'(st_eg_r[sidx_r]) < 32'(NUM_IFACES)) &&
               up[IW'(st_eg_r[sidx_r])];
        c_if = st_eg_r[sidx_r];
        c_direct = 1'b1;
      end else begin
        c_ok  = st_valid_r[sidx_r] && st_hashop_r[sidx_r] && hop_hit;
        c_if  = hop_if;
        c_hop = st_hop_r[sidx_r];
      end
    end
    c_mask = rtlpm_pkg::len_mask(c_len);
    c_net  = c_base & c_mask;
    c_ok   = c_ok && ((item_r.address & c_mask) == c_net);
  end

  logic take;
  assign take = c_ok && (!have_r || c_len > b_len_r ||
                (c_static && c_len == b_len_r && c_pref < b_pref_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtlpm_pkg::ST_IDLE:
        if (in_fire) begin
          state_nxt = (in_ch.data.opcode == rtlpm_pkg::OP_LOOKUP) ?
                      rtlpm_pkg::ST_IFACE : rtlpm_pkg::ST_DONE;
        end
      rtlpm_pkg::ST_IFACE:  if (last_if) state_nxt = rtlpm_pkg::ST_STATIC;
      rtlpm_pkg::ST_STATIC: if (last_st) state_nxt = rtlpm_pkg::ST_DONE;
      rtlpm_pkg::ST_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = rtlpm_pkg::ST_IDLE;
      default: state_nxt = rtlpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == rtlpm_pkg::ST_IDLE);
    out_ch.valid = out_valid_r;
    out_ch.data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtlpm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      if_admin_r <= '0;
      if_oper_r <= '0;
      st_valid_r <= '0;
      iidx_r <= '0;
      sidx_r <= '0;
      have_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        item_r <= in_ch.data;
        iidx_r <= '0;
        sidx_r <= '0;
        have_r <= 1'b0;
        unique case (rtlpm_pkg::op_t'(in_ch.data.opcode))
          rtlpm_pkg::OP_WR_IFACE:
            if (32'(in_ch.data.slot) < 32'(NUM_IFACES)) begin
              if_addr_r[IW'(in_ch.data.slot)]  <= in_ch.data.address;
              if_len_r[IW'(in_ch.data.slot)]   <= in_ch.data.pfx_len;
              if_admin_r[IW'(in_ch.data.slot)] <= in_ch.data.admin_up;
              if_oper_r[IW'(in_ch.data.slot)]  <= in_ch.data.oper_up;
            end
          rtlpm_pkg::OP_WR_STATIC:
            if (32'(in_ch.data.slot) < 32'(NUM_STATIC)) begin
              st_pfx_r[SW'(in_ch.data.slot)]    <= in_ch.data.address;
              st_len_r[SW'(in_ch.data.slot)]    <= in_ch.data.pfx_len;
              st_pref_r[SW'(in_ch.data.slot)]   <= in_ch.data.preference;
              st_valid_r[SW'(in_ch.data.slot)]  <= in_ch.data.admin_up;
              st_haseg_r[SW'(in_ch.data.slot)]  <= in_ch.data.egress_valid;
              st_eg_r[SW'(in_ch.data.slot)]     <= in_ch.data.egress_index;
              st_hop_r[SW'(in_ch.data.slot)]    <= in_ch.data.hop_addr;
              st_hashop_r[SW'(in_ch.data.slot)] <= in_ch.data.hop_valid;
            end
          rtlpm_pkg::OP_SET_OPER:
            if (32'(in_ch.data.slot) < 32'(NUM_IFACES))
              if_oper_r[IW'(in_ch.data.slot)] <= in_ch.data.oper_up;
          rtlpm_pkg::OP_LOOKUP: ;
          default: ;
        endcase
      end
      if (state_r == rtlpm_pkg::ST_IFACE || state_r == rtlpm_pkg::ST_STATIC) begin
        if (state_r == rtlpm_pkg::ST_IFACE && !last_if) iidx_r <= iidx_r + 1'b1;
        if (state_r == rtlpm_pkg::ST_STATIC && !last_st) sidx_r <= sidx_r + 1'b1;
        if (take) begin
          have_r <= 1'b1;
          b_len_r <= c_len; b_pref_r <= c_pref; b_if_r <= c_if; b_hop_r <= c_hop;
          b_net_r <= c_net; b_direct_r <= c_direct; b_static_r <= c_static;
        end
      end
      if (state_r == rtlpm_pkg::ST_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        if (item_r.opcode == rtlpm_pkg::OP_LOOKUP && have_r) begin
          out_data_r.found            <= 1'b1;
          out_data_r.out_interface    <= b_if_r;
          out_data_r.is_direct        <= b_direct_r;
          out_data_r.out_hop          <= b_direct_r ? 32'd0 : b_hop_r;
          out_data_r.route_prefix     <= b_net_r;
          out_data_r.route_len        <= b_len_r;
          out_data_r.from_static      <= b_static_r;
          out_data_r.route_preference <= b_pref_r;
        end else begin
          out_data_r <= '0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(state_r == rtlpm_pkg::ST_STATIC)) else $error("ready mid lookup");
  ap_iface_to_static: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtlpm_pkg::ST_IFACE && last_if) |=> state_r == rtlpm_pkg::ST_STATIC)
    else $error("iface walk end");
  ap_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.data.opcode != rtlpm_pkg::OP_LOOKUP) |=> state_r == rtlpm_pkg::ST_DONE)
    else $error("write path");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("result dropped while stalled");

endmodule
`default_nettype wire
